// ----- rtl/mtspwm_pkg.sv -----
`default_nettype none

package mtspwm_pkg;

    // Channel table geometry
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

    // Field widths
    localparam int PERIOD_W = 20;
    localparam int DUTY_W   = 7;
    localparam int LEFT_W   = 22;
    localparam int PINS_W   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;
    localparam logic [DUTY_W-1:0]   PCT_FULL     = 7'd100;

    // floor(x / 100) = floor(floor(x / 4) * DIV_MUL / 2^DIV_SHIFT) for x < 2^27
    localparam int          PROD_W    = PERIOD_W + DUTY_W;
    localparam int          DIV_SHIFT = 30;
    localparam logic [25:0] DIV_MUL   = 26'd42949673;
    localparam int          SCL_W     = (PROD_W - 2) + 26;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET_ONE = 2'd1,
        CMD_SET_ALL = 2'd2
    } mtspwm_cmd_t;

    typedef enum logic {
        REG_PERIOD  = 1'b0,
        REG_MAKE_UP = 1'b1
    } mtspwm_reg_t;

    // One row of the channel table
    typedef struct packed {
        logic [DUTY_W-1:0]          duty;
        logic [PERIOD_W-1:0]        on_len;
        logic [PERIOD_W-1:0]        off_len;
        logic signed [LEFT_W-1:0]   on_left;
        logic signed [LEFT_W-1:0]   off_left;
    } mtspwm_entry_t;

    // Pin level change requested by one channel step
    typedef struct packed {
        logic upd;
        logic high;
    } mtspwm_lvl_t;

endpackage

`default_nettype wire

// ----- rtl/mtspwm_chan_step.sv -----
`default_nettype none

module mtspwm_chan_step (
    input  wire mtspwm_pkg::mtspwm_entry_t        entry,
    input  wire logic [mtspwm_pkg::PERIOD_W-1:0]  elapsed,
    input  wire logic                             make_up,
    output mtspwm_pkg::mtspwm_entry_t             entry_new,
    output mtspwm_pkg::mtspwm_lvl_t               lvl
);

    localparam int T_W = mtspwm_pkg::LEFT_W + 2;

    function automatic logic signed [mtspwm_pkg::LEFT_W-1:0] clamp_left(
        input logic signed [T_W-1:0] v
    );
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
        lo = -(T_W'(1) <<< (mtspwm_pkg::LEFT_W - 1));
        hi = (T_W'(1) <<< (mtspwm_pkg::LEFT_W - 1)) - T_W'(1);
        if (v < lo)
            clamp_left = lo[mtspwm_pkg::LEFT_W-1:0];
        else if (v > hi)
            clamp_left = hi[mtspwm_pkg::LEFT_W-1:0];
        else
            clamp_left = v[mtspwm_pkg::LEFT_W-1:0];
    endfunction

    logic                             active;
    logic signed [T_W-1:0]            on_dec;
    logic signed [T_W-1:0]            off_dec;
    logic signed [T_W-1:0]            on_reload;
    logic signed [T_W-1:0]            off_reload;
    logic signed [mtspwm_pkg::LEFT_W-1:0] off_cnt;

    assign active = (entry.duty != '0) && (entry.duty < mtspwm_pkg::PCT_FULL);

    always_comb
    begin
        on_dec  = $signed({{2{entry.on_left[mtspwm_pkg::LEFT_W-1]}}, entry.on_left})
                - $signed({4'd0, elapsed});
        off_dec = $signed({{2{entry.off_left[mtspwm_pkg::LEFT_W-1]}}, entry.off_left})
                - $signed({4'd0, elapsed});
        off_cnt = clamp_left(off_dec);
        // Make-up reload: add the (non-positive) leftover to the length
        on_reload  = $signed({4'd0, entry.on_len})
                   + $signed({{2{entry.on_left[mtspwm_pkg::LEFT_W-1]}}, entry.on_left});
        off_reload = $signed({4'd0, entry.off_len})
                   + $signed({{2{off_cnt[mtspwm_pkg::LEFT_W-1]}}, off_cnt});

        entry_new = entry;
        lvl       = '0;
        if (active) begin
            if ($signed(entry.on_left) > 0) begin
                entry_new.on_left = clamp_left(on_dec);
                if (on_dec <= 0) begin
                    lvl.upd  = 1'b1;
                    lvl.high = 1'b0;
                end
            end else if ($signed(entry.off_left) > 0) begin
                entry_new.off_left = off_cnt;
                if (off_cnt <= 0) begin
                    if (make_up) begin
                        entry_new.on_left  = clamp_left(on_reload);
                        entry_new.off_left = clamp_left(off_reload);
                    end else begin
                        entry_new.on_left  = $signed({2'b00, entry.on_len});
                        entry_new.off_left = $signed({2'b00, entry.off_len});
                    end
                    lvl.upd  = 1'b1;
                    lvl.high = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/multichannel_time_sliced_pwm_core.sv -----
`default_nettype none

// Multichannel PWM generator driven by commands. Each accepted beat on the
// input channel is one command: a tick that advances every channel by
// elapsed_us, a duty write for one channel, or a duty write for all
// channels; each command returns exactly one result beat holding the pin
// levels after the command and an accepted flag (duty above 100, a channel
// out of range or an unknown command give accepted = 0 and change nothing).
// The per-channel counts and lengths live in one synchronous table with
// one read and one write port, one row per channel, and the pin levels in a
// register beside it, so the block works on one command at a time. A tick
// walks the table at one row per cycle; a single duty write forms period *
// duty / 100 in two registered multiply steps, then splits the period and
// writes the row; a set-all write does the same, then writes one table row
// per cycle; a rejected command goes straight to the result. A new command
// is taken while the previous result still waits in the output register.
// Changing period_us only affects later duty writes. Configuration writes
// are taken in any cycle and must only be issued while idle.
module multichannel_time_sliced_pwm_core (
    input  wire  logic        clk,
    input  wire  logic        rst_n,

    // Command channel
    input  wire  logic        in_valid,
    output       logic        in_stall,
    input  wire  logic [1:0]  command,
    input  wire  logic [4:0]  channel,
    input  wire  logic [6:0]  duty_percent,
    input  wire  logic [19:0] elapsed_us,

    // Result channel
    output       logic        out_valid,
    input  wire  logic        out_stall,
    output       logic [31:0] pin_levels,
    output       logic        accepted,

    // Configuration write channel
    input  wire  logic        cfg_valid,
    output       logic        cfg_ready,
    input  wire  logic        cfg_index,
    input  wire  logic [19:0] cfg_data
);

    localparam int N      = mtspwm_pkg::NUM_CHANNELS;
    localparam int CH_W   = mtspwm_pkg::CH_W;
    localparam int CNT_W  = mtspwm_pkg::CNT_W;
    localparam int PER_W  = mtspwm_pkg::PERIOD_W;
    localparam int DUTY_W = mtspwm_pkg::DUTY_W;
    localparam int PROD_W = mtspwm_pkg::PROD_W;
    localparam int SCL_W  = mtspwm_pkg::SCL_W;
    localparam int SH     = mtspwm_pkg::DIV_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_SCALE,
        ST_SPLIT,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Channel table: one row per channel, read data registered
    mtspwm_pkg::mtspwm_entry_t mem [N];
    mtspwm_pkg::mtspwm_entry_t rd_data_reg;

    logic                      mem_we;
    logic [CH_W-1:0]           mem_wa;
    logic [CH_W-1:0]           mem_ra;
    mtspwm_pkg::mtspwm_entry_t mem_wd;

    state_t                 state_reg,    state_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [1:0]             cmd_reg,      cmd_next;
    logic [CH_W-1:0]        ch_reg,       ch_next;
    logic [DUTY_W-1:0]      duty_reg,     duty_next;
    logic [PER_W-1:0]       elapsed_reg,  elapsed_next;
    logic                   ok_reg,       ok_next;
    logic [PROD_W-1:0]      prod_reg,     prod_next;
    logic [SCL_W-1:0]       scl_reg,      scl_next;
    logic [PER_W-1:0]       on_len_reg,   on_len_next;
    logic [PER_W-1:0]       off_len_reg,  off_len_next;
    logic                   rd_pend_reg,  rd_pend_next;
    logic [CH_W-1:0]        rd_addr_reg,  rd_addr_next;
    logic                   rd_vld_reg,   rd_vld_next;
    logic [N-1:0]           vld_reg,      vld_next;
    logic [N-1:0]           level_reg,    level_next;
    logic                   out_valid_reg, out_valid_next;
    logic [31:0]            pins_reg,     pins_next;
    logic                   acc_reg,      acc_next;
    logic [PER_W-1:0]       period_reg,   period_next;
    logic                   make_up_reg,  make_up_next;

    mtspwm_pkg::mtspwm_entry_t cur_entry;
    mtspwm_pkg::mtspwm_entry_t step_entry;
    mtspwm_pkg::mtspwm_lvl_t   step_lvl;
    logic [63:0]               level_wide;
    logic [PER_W-1:0]          on_calc;

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign pin_levels = pins_reg;
    assign accepted   = acc_reg;

    // A row never written reads as all zero
    assign cur_entry  = rd_vld_reg ? rd_data_reg : '0;
    assign level_wide = 64'(level_reg);
    assign on_calc    = scl_reg[SH+PER_W-1:SH];

    mtspwm_chan_step u_step (
        .entry     (cur_entry),
        .elapsed   (elapsed_reg),
        .make_up   (make_up_reg),
        .entry_new (step_entry),
        .lvl       (step_lvl)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        ch_next        = ch_reg;
        duty_next      = duty_reg;
        elapsed_next   = elapsed_reg;
        ok_next        = ok_reg;
        prod_next      = prod_reg;
        scl_next       = scl_reg;
        on_len_next    = on_len_reg;
        off_len_next   = off_len_reg;
        rd_pend_next   = 1'b0;
        rd_addr_next   = rd_addr_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg;
        pins_next      = pins_reg;
        acc_next       = acc_reg;
        period_next    = period_reg;
        make_up_next   = make_up_reg;

        mem_we = 1'b0;
        mem_wa = ch_reg;
        mem_ra = cnt_reg[CH_W-1:0];
        mem_wd = step_entry;

        // Drop the result once the downstream side takes it
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                mtspwm_pkg::REG_PERIOD:  period_next  = cfg_data;
                mtspwm_pkg::REG_MAKE_UP: make_up_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd_next     = command;
                    ch_next      = CH_W'(channel);
                    duty_next    = duty_percent;
                    elapsed_next = elapsed_us;
                    cnt_next     = '0;
                    case (command)
                        mtspwm_pkg::CMD_TICK:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_WALK;
                        end
                        mtspwm_pkg::CMD_SET_ONE:
                        begin
                            if ((duty_percent <= mtspwm_pkg::PCT_FULL) &&
                                ({27'd0, channel} < 32'(N))) begin
                                ok_next    = 1'b1;
                                state_next = ST_MUL;
                            end else begin
                                ok_next    = 1'b0;
                                state_next = ST_DONE;
                            end
                        end
                        mtspwm_pkg::CMD_SET_ALL:
                        begin
                            if (duty_percent <= mtspwm_pkg::PCT_FULL) begin
                                ok_next    = 1'b1;
                                state_next = ST_MUL;
                            end else begin
                                ok_next    = 1'b0;
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // Issue the read of the next row while the previous one
                // is stepped and written back; rows never overlap.
                if (cnt_reg < CNT_W'(N)) begin
                    rd_pend_next = 1'b1;
                    rd_addr_next = cnt_reg[CH_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                if (rd_pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = rd_addr_reg;
                    mem_wd = step_entry;
                    if (step_lvl.upd)
                        level_next[rd_addr_reg] = step_lvl.high;
                end
                if ((cnt_reg == CNT_W'(N)) && !rd_pend_reg)
                    state_next = ST_DONE;
            end

            ST_MUL:
            begin
                prod_next  = {{DUTY_W{1'b0}}, period_reg} * {{PER_W{1'b0}}, duty_reg};
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                // Divide by 100: drop the low two bits (divide by 4), then multiply by 2^30/25
                scl_next   = {26'd0, prod_reg[PROD_W-1:2]}
                           * {(PROD_W - 2)'(0), mtspwm_pkg::DIV_MUL};
                state_next = ST_SPLIT;
            end

            ST_SPLIT:
            begin
                on_len_next  = on_calc;
                off_len_next = period_reg - on_calc;
                state_next   = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                mem_we           = 1'b1;
                mem_wd.duty      = duty_reg;
                mem_wd.on_len    = on_len_reg;
                mem_wd.off_len   = off_len_reg;
                mem_wd.on_left   = $signed({2'b00, on_len_reg});
                mem_wd.off_left  = $signed({2'b00, off_len_reg});
                if (cmd_reg == mtspwm_pkg::CMD_SET_ALL) begin
                    mem_wa     = cnt_reg[CH_W-1:0];
                    level_next = {N{duty_reg != '0}};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(N - 1))
                        state_next = ST_DONE;
                end else begin
                    mem_wa             = ch_reg;
                    level_next[ch_reg] = (duty_reg != '0);
                    state_next         = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    pins_next      = level_wide[31:0];
                    acc_next       = ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_vld_next = vld_reg[mem_ra];
        vld_next    = vld_reg;
        if (mem_we)
            vld_next[mem_wa] = 1'b1;
    end

    // Channel table storage
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmd_reg       <= '0;
            ch_reg        <= '0;
            duty_reg      <= '0;
            elapsed_reg   <= '0;
            ok_reg        <= 1'b0;
            prod_reg      <= '0;
            scl_reg       <= '0;
            on_len_reg    <= '0;
            off_len_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            vld_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            pins_reg      <= '0;
            acc_reg       <= 1'b0;
            period_reg    <= mtspwm_pkg::PERIOD_RESET;
            make_up_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            ch_reg        <= ch_next;
            duty_reg      <= duty_next;
            elapsed_reg   <= elapsed_next;
            ok_reg        <= ok_next;
            prod_reg      <= prod_next;
            scl_reg       <= scl_next;
            on_len_reg    <= on_len_next;
            off_len_reg   <= off_len_next;
            rd_pend_reg   <= rd_pend_next;
            rd_addr_reg   <= rd_addr_next;
            rd_vld_reg    <= rd_vld_next;
            vld_reg       <= vld_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            pins_reg      <= pins_next;
            acc_reg       <= acc_next;
            period_reg    <= period_next;
            make_up_reg   <= make_up_next;
        end
    end

endmodule

`default_nettype wire

// ----- test/multichannel_time_sliced_pwm_core_tb.sv -----
`timescale 1ns / 1ps

module multichannel_time_sliced_pwm_core_tb;

    // Command code that the block must reject
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Saturation bounds of the remaining-time counters
    localparam longint REM_MIN = -64'sd2097152;
    localparam longint REM_MAX = 64'sd2097151;

    // Hard stop for the whole run, far above the slowest legal run
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // Cycles to watch for stray result beats once nothing is pending
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic [31:0] pins;
        logic        ok;
    } pwm_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [4:0]  channel;
    logic [6:0]  duty_percent;
    logic [19:0] elapsed_us;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] pin_levels;
    logic        accepted;

    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [19:0] cfg_data;

    // Shadow of the block's channel table and registers
    logic [6:0]         duty_tab [mtspwm_pkg::NUM_CHANNELS];
    logic [19:0]        on_len   [mtspwm_pkg::NUM_CHANNELS];
    logic [19:0]        off_len  [mtspwm_pkg::NUM_CHANNELS];
    logic signed [21:0] on_rem   [mtspwm_pkg::NUM_CHANNELS];
    logic signed [21:0] off_rem  [mtspwm_pkg::NUM_CHANNELS];
    logic [31:0]        pin_state;
    logic [19:0]        period_cfg;
    logic               make_up_cfg;

    // Pin levels still owed by the block, oldest first
    pwm_beat_t levels_due [$];

    int mismatches = 0;
    int stall_left = 0;
    bit jitter_on  = 1'b1;

    multichannel_time_sliced_pwm_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .channel      (channel),
        .duty_percent (duty_percent),
        .elapsed_us   (elapsed_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pin_levels   (pin_levels),
        .accepted     (accepted),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Channel model
    // ------------------------------------------------------------------

    function automatic logic signed [21:0] clamp_rem(input longint v);
        if (v < REM_MIN)
            return REM_MIN[21:0];
        if (v > REM_MAX)
            return REM_MAX[21:0];
        return v[21:0];
    endfunction

    // Load a new duty: both lengths come from the period in force right now,
    // and the pin goes high for any nonzero duty.
    function automatic void load_channel(input int c, input logic [6:0] pct);
        logic [19:0] on_us;
        on_us = 20'((longint'(period_cfg) * longint'(pct))
                    / longint'(mtspwm_pkg::PCT_FULL));
        duty_tab[c]  = pct;
        on_len[c]    = on_us;
        off_len[c]   = period_cfg - on_us;
        on_rem[c]    = $signed({2'b00, on_us});
        off_rem[c]   = $signed({2'b00, period_cfg - on_us});
        pin_state[c] = (pct != '0);
    endfunction

    // Advance one channel by one tick. A duty of 0 or 100 holds the pin.
    // The on phase runs first; once it is spent the off phase runs, and its
    // end reloads both counts (minus the overshoot in make-up mode).
    function automatic void step_channel(input int c, input logic [19:0] us);
        if (duty_tab[c] == '0 || duty_tab[c] >= mtspwm_pkg::PCT_FULL)
            return;
        if (on_rem[c] > 0)
        begin
            on_rem[c] = clamp_rem(longint'(on_rem[c]) - longint'(us));
            if (on_rem[c] <= 0)
                pin_state[c] = 1'b0;
        end
        else if (off_rem[c] > 0)
        begin
            off_rem[c] = clamp_rem(longint'(off_rem[c]) - longint'(us));
            if (off_rem[c] <= 0)
            begin
                if (make_up_cfg)
                begin
                    on_rem[c]  = clamp_rem(longint'(on_len[c]) + longint'(on_rem[c]));
                    off_rem[c] = clamp_rem(longint'(off_len[c]) + longint'(off_rem[c]));
                end
                else
                begin
                    on_rem[c]  = $signed({2'b00, on_len[c]});
                    off_rem[c] = $signed({2'b00, off_len[c]});
                end
                pin_state[c] = 1'b1;
            end
        end
    endfunction

    // Apply one command to the shadow table and return the beat it owes.
    function automatic pwm_beat_t apply_command(input logic [1:0] op, input logic [4:0] ch,
                                                input logic [6:0] pct, input logic [19:0] us);
        pwm_beat_t beat;
        beat.ok = 1'b0;
        case (op)
            mtspwm_pkg::CMD_TICK:
            begin
                for (int c = 0; c < mtspwm_pkg::NUM_CHANNELS; c++)
                    step_channel(c, us);
                beat.ok = 1'b1;
            end
            mtspwm_pkg::CMD_SET_ONE:
            begin
                if (pct <= mtspwm_pkg::PCT_FULL && ch < mtspwm_pkg::NUM_CHANNELS)
                begin
                    load_channel(ch, pct);
                    beat.ok = 1'b1;
                end
            end
            mtspwm_pkg::CMD_SET_ALL:
            begin
                if (pct <= mtspwm_pkg::PCT_FULL)
                begin
                    for (int c = 0; c < mtspwm_pkg::NUM_CHANNELS; c++)
                        load_channel(c, pct);
                    beat.ok = 1'b1;
                end
            end
            default:
            begin
                // unknown command: nothing changes
            end
        endcase
        beat.pins = pin_state;
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
    endtask

    // Sample every handshake at the rising edge. Check the result beat first,
    // then track config writes and predict newly accepted commands.
    always @(posedge clk)
    begin : watch
        pwm_beat_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (levels_due.size() == 0)
                    report_mismatch("result beat with nothing pending", pin_levels, '0);
                else
                begin
                    want = levels_due.pop_front();
                    if (pin_levels !== want.pins)
                        report_mismatch("pin_levels", pin_levels, want.pins);
                    if (accepted !== want.ok)
                        report_mismatch("accepted", 32'(accepted), 32'(want.ok));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mtspwm_pkg::REG_PERIOD)
                    period_cfg = cfg_data;
                else
                    make_up_cfg = cfg_data[0];
            end
            if (in_valid && !in_stall)
                levels_due.push_back(apply_command(command, channel, duty_percent, elapsed_us));
        end
    end

    // Throttle the result side in short bursts while jitter is enabled.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall = 1'b0;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drop the command valid; the argument sets how long it stays low.
    task automatic hold_cmd(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Present one command beat and hold it until the block takes it. Valid
    // stays high afterwards so the next beat can follow back to back.
    task automatic send_cmd(input logic [1:0] op, input logic [4:0] ch,
                            input logic [6:0] pct, input logic [19:0] us);
        if (jitter_on && $urandom_range(0, 3) == 0)
            hold_cmd($urandom_range(1, 4));
        @(negedge clk);
        command      = op;
        channel      = ch;
        duty_percent = pct;
        elapsed_us   = us;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic tick(input logic [19:0] us);
        send_cmd(mtspwm_pkg::CMD_TICK, 5'($urandom), 7'($urandom), us);
    endtask

    task automatic set_one(input logic [4:0] ch, input logic [6:0] pct);
        send_cmd(mtspwm_pkg::CMD_SET_ONE, ch, pct, 20'($urandom));
    endtask

    task automatic set_all(input logic [6:0] pct);
        send_cmd(mtspwm_pkg::CMD_SET_ALL, 5'($urandom), pct, 20'($urandom));
    endtask

    // Stop sending and wait until every owed beat has come back.
    task automatic wait_idle();
        hold_cmd(1);
        while (levels_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input mtspwm_pkg::mtspwm_reg_t idx, input logic [19:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Reprogram both registers; only legal with nothing in flight.
    task automatic configure(input logic [19:0] period, input logic make_up);
        wait_idle();
        write_reg(mtspwm_pkg::REG_PERIOD, period);
        write_reg(mtspwm_pkg::REG_MAKE_UP, 20'(make_up));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All duties are zero after reset: ticks of any length keep every pin low.
    task automatic test_reset_levels();
        tick('0);
        tick('1);
    endtask

    // Reject duties above 100 and the unused command, force pins for 0 and
    // 100, then run a duty of 1 and 99 through one full period.
    task automatic test_duty_writes();
        set_all(7'd101);
        set_all(7'd100);
        set_all(7'd0);
        set_one(5'd31, 7'd100);
        set_one(5'd0, 7'd1);
        set_one(5'd16, 7'd99);
        set_one(5'd10, 7'd101);
        set_one(5'd21, 7'd127);
        send_cmd(CMD_UNUSED, 5'($urandom), 7'($urandom), 20'($urandom));
        tick(20'd10);
        tick(20'd980);
        tick(20'd10);
    endtask

    // Make-up mode with a period of 10: overshoot shortens the next period,
    // a reload that is not positive skips the on phase, and a zero on length
    // keeps the pin high from the start.
    task automatic test_make_up_reload();
        configure(20'd10, 1'b1);
        set_all(7'd30);
        set_one(5'd2, 7'd5);
        tick(20'd5);
        tick(20'd12);
        tick(20'd1);
        tick(20'd1);
    endtask

    // Period of zero leaves every channel idle; a period of 1000000 with a
    // tick of the largest elapsed time exercises the widest counts.
    task automatic test_period_extremes();
        configure(20'd0, 1'b0);
        set_one(5'd3, 7'd60);
        tick(20'd100);
        configure(20'd1000000, 1'b0);
        set_one(5'd4, 7'd99);
        tick('1);
    endtask

    // Random commands sized to the current period, so that phases end often.
    task automatic run_random_items(input int count);
        int          sel;
        logic [6:0]  pct;
        logic [19:0] us;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                pct = 7'd0;
            else if (sel < 10)
                pct = 7'd100;
            else if (sel < 88)
                pct = 7'($urandom_range(1, 99));
            else
                pct = 7'($urandom_range(101, 127));
            if ($urandom_range(0, 11) == 0)
                us = 20'($urandom);
            else
                us = 20'($urandom_range(0, period_cfg / 2 + 2));
            sel = $urandom_range(0, 99);
            if (sel < 50)
                send_cmd(mtspwm_pkg::CMD_TICK, 5'($urandom), 7'($urandom), us);
            else if (sel < 82)
                send_cmd(mtspwm_pkg::CMD_SET_ONE, 5'($urandom), pct, us);
            else if (sel < 92)
                send_cmd(mtspwm_pkg::CMD_SET_ALL, 5'($urandom), pct, us);
            else
                send_cmd(CMD_UNUSED, 5'($urandom), 7'($urandom), us);
        end
    endtask

    task automatic test_random_traffic();
        configure(20'd1000, 1'b0);
        run_random_items(70);
        configure(20'd1, 1'b1);
        run_random_items(60);
        configure(20'd10, 1'b1);
        run_random_items(70);
        configure(20'd1000000, 1'b0);
        run_random_items(60);
        configure(20'd1000000, 1'b1);
        run_random_items(50);
        configure(20'($urandom_range(1, 1000000)), 1'b1);
        run_random_items(70);
        configure(20'($urandom_range(2, 200)), 1'b0);
        run_random_items(60);
        // last stretch at full rate on both sides
        configure(20'd37, 1'b1);
        jitter_on = 1'b0;
        run_random_items(80);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = mtspwm_pkg::CMD_TICK;
        channel      = '0;
        duty_percent = '0;
        elapsed_us   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = mtspwm_pkg::REG_PERIOD;
        cfg_data     = '0;

        // shadow state as it comes out of reset
        period_cfg  = mtspwm_pkg::PERIOD_RESET;
        make_up_cfg = 1'b0;
        pin_state   = '0;
        for (int c = 0; c < mtspwm_pkg::NUM_CHANNELS; c++)
        begin
            duty_tab[c] = '0;
            on_len[c]   = '0;
            off_len[c]  = '0;
            on_rem[c]   = '0;
            off_rem[c]  = '0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_levels();
        test_duty_writes();
        test_make_up_reload();
        test_period_extremes();
        test_random_traffic();

        // drain, then watch a while for stray beats
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d beats still pending", levels_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mtspwm_pkg.sv
rtl/mtspwm_chan_step.sv
rtl/multichannel_time_sliced_pwm_core.sv
test/multichannel_time_sliced_pwm_core_tb.sv
